// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the Hampel filter RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and synchronous reset.
`define HOF_ASSERT_ON(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("hof assertion failed");

// Block form: uses the module's clock and reset ports.
`define HOF_ASSERT(label, prop) `HOF_ASSERT_ON(label, clock, reset, prop)

`endif

// ===== design/hof_pkg.sv =====
// ---------------------------------------------------------------------------
// hof_pkg
// Constants and types shared by the Hampel outlier filter modules.
// ---------------------------------------------------------------------------
package hof_pkg;

   localparam int WINDOW_LEN   = 5;
   localparam int SAMPLE_W     = 32;
   localparam int DATA_W       = SAMPLE_W + 1;  // sort key: sample or abs deviation
   localparam int THR_W        = 16;
   localparam int SCALE_W      = 17;
   localparam int PROD_W       = THR_W + SCALE_W;
   localparam int LOW_PROD_W   = 2 * SAMPLE_W;
   localparam int BOUND_W      = PROD_W + SAMPLE_W;
   localparam int FRAC_SHIFT   = 24;            // Q8.8 x Q1.16
   localparam int CENTER_IDX   = WINDOW_LEN / 2;
   localparam int MEDIAN_RANK  = WINDOW_LEN / 2;
   localparam int SORT_CYCLES  = 2 * WINDOW_LEN;
   localparam int CNT_W        = $clog2(SORT_CYCLES);
   localparam int IDX_W        = $clog2(WINDOW_LEN);

   localparam logic [SCALE_W-1:0] SCALE_Q1_16 = SCALE_W'(97164);  // 1.4826
   localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(512);      // 2.0

   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] data;
   } link_type;

endpackage

// ===== design/hof_sort_cell.sv =====
// ---------------------------------------------------------------------------
// hof_sort_cell
// One insertion-sort cell: keeps the smallest key seen, passes the rest on.
// ---------------------------------------------------------------------------
module hof_sort_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             clear,
   input  hof_pkg::link_type                link_in,
   output hof_pkg::link_type                link_out,
   output logic signed [hof_pkg::DATA_W-1:0] held_value
);

   logic                              held_valid_ff, held_valid_in;
   logic signed [hof_pkg::DATA_W-1:0] held_ff, held_in;
   hof_pkg::link_type                 pass_ff, pass_in;

   always_comb begin
      held_valid_in = held_valid_ff;
      held_in       = held_ff;
      pass_in.valid = 1'b0;
      pass_in.data  = link_in.data;
      if (link_in.valid) begin
         if (!held_valid_ff) begin
            held_valid_in = 1'b1;
            held_in       = link_in.data;
         end else if ($signed(link_in.data) < $signed(held_ff)) begin
            held_in       = link_in.data;
            pass_in.data  = held_ff;
            pass_in.valid = 1'b1;
         end else begin
            pass_in.valid = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         held_valid_ff <= 1'b0;
         pass_ff.valid <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
         pass_ff.valid <= pass_in.valid;
      end
      held_ff      <= held_in;
      pass_ff.data <= pass_in.data;
   end

   assign link_out   = pass_ff;
   assign held_value = held_ff;

endmodule

// ===== design/hof_sort_chain.sv =====
// ---------------------------------------------------------------------------
// hof_sort_chain
// Systolic row of sort cells; after a full load cell k holds rank k.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hof_sort_chain (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             clear,
   input  hof_pkg::link_type                feed,
   output logic signed [hof_pkg::DATA_W-1:0] median_value
);

   hof_pkg::link_type links [hof_pkg::WINDOW_LEN+1];

   assign links[0] = feed;

   for (genvar g = 0; g < hof_pkg::WINDOW_LEN; g++) begin : g_cell
      if (g == hof_pkg::MEDIAN_RANK) begin : g_mid
         hof_sort_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .clear      (clear),
            .link_in    (links[g]),
            .link_out   (links[g+1]),
            .held_value (median_value)
         );
      end else begin : g_side
         hof_sort_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .clear      (clear),
            .link_in    (links[g]),
            .link_out   (links[g+1]),
            .held_value ()
         );
      end
   end

   // one key per cell after each clear: the last cell never spills
   `HOF_ASSERT(a_chain_no_spill, !links[hof_pkg::WINDOW_LEN].valid)

endmodule

// ===== design/hampel_outlier_filter.sv =====
// A transferred sample steps through SORT_VAL, SORT_DEV, SCALE, PRODUCT and DECIDE, held
//   until the result register is free. One item at a time: req_tready is low out of IDLE;
//   the single sort chain is loaded twice per item (samples, then abs deviations).
// The result register frees the input side while a result waits on rsp_tready.
// Reset (synchronous, active high): window and outlier count zero, threshold 2.0.
// ---------------------------------------------------------------------------
// hampel_outlier_filter
// Hampel filter over a sliding window: median / MAD test on the centre sample.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hampel_outlier_filter (
   input  logic        clock,
   input  logic        reset,
   // sample stream in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [31:0] sample_in
   // filtered stream out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,    // [31:0] sample_out, [63:32] outliers_seen
   output logic        rsp_tuser,    // [0] outlier_flag
   // threshold register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_wdata     // [15:0] threshold_q8_8
);

   localparam int SW = hof_pkg::SAMPLE_W;
   localparam int DW = hof_pkg::DATA_W;
   localparam int NW = hof_pkg::WINDOW_LEN;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SORT_VAL,   // load raw samples, median settles
      ST_SORT_DEV,   // load abs deviations, MAD settles
      ST_SCALE,      // threshold x 1.4826
      ST_PRODUCT,    // low 32 bits of scale x MAD
      ST_DECIDE      // top bit fold-in, compare, load result
   } state_type;

   state_type                          state_ff, state_in;
   logic [hof_pkg::CNT_W-1:0]          cnt_ff, cnt_in;
   logic signed [SW-1:0]               window_ff [NW];
   logic signed [SW-1:0]               window_in [NW];
   logic [hof_pkg::THR_W-1:0]          threshold_ff, threshold_in;
   logic signed [DW-1:0]               med_ff, med_in;
   logic [SW-1:0]                      dev_ff, dev_in;
   logic [SW-1:0]                      mad_ff, mad_in;
   logic [hof_pkg::PROD_W-1:0]         scale_ff, scale_in;
   logic [hof_pkg::LOW_PROD_W-1:0]     prod_lo_ff, prod_lo_in;
   logic [SW-1:0]                      count_ff, count_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]                      sample_out_ff, sample_out_in;
   logic                               flag_ff, flag_in;
   logic [SW-1:0]                      seen_ff, seen_in;

   logic                               req_xfer;
   logic                               out_free;
   logic                               out_load;
   logic                               last_cnt;
   logic                               feed_on;
   logic [hof_pkg::IDX_W-1:0]          feed_idx;
   logic signed [DW-1:0]               feed_sample;
   logic signed [DW-1:0]               feed_diff;
   logic signed [DW-1:0]               feed_abs;
   logic signed [DW-1:0]               center_ext;
   logic signed [DW-1:0]               center_diff;
   logic signed [DW-1:0]               center_abs;
   logic [hof_pkg::BOUND_W-1:0]        bound;
   logic [hof_pkg::BOUND_W-1:0]        lhs;
   logic                               pass_s;
   logic                               chain_clear;
   hof_pkg::link_type                  chain_feed;
   logic signed [DW-1:0]               chain_median;

   hof_sort_chain u_chain (
      .clock        (clock),
      .reset        (reset),
      .clear        (chain_clear),
      .feed         (chain_feed),
      .median_value (chain_median)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign last_cnt   = (cnt_ff == hof_pkg::CNT_W'(hof_pkg::SORT_CYCLES - 1));

   // feed one window tap per cycle while cnt_ff is below WINDOW_LEN in a sort phase
   assign feed_on     = (cnt_ff < hof_pkg::CNT_W'(NW));
   assign feed_idx    = feed_on ? cnt_ff[hof_pkg::IDX_W-1:0] : '0;
   assign feed_sample = {window_ff[feed_idx][SW-1], window_ff[feed_idx]};
   assign feed_diff   = feed_sample - med_ff;
   assign feed_abs    = feed_diff[DW-1] ? -feed_diff : feed_diff;

   assign chain_feed.valid = feed_on &&
                             ((state_ff == ST_SORT_VAL) || (state_ff == ST_SORT_DEV));
   assign chain_feed.data  = (state_ff == ST_SORT_DEV) ? feed_abs : feed_sample;

   // centre deviation, taken when the median leaves the chain
   assign center_ext  = {window_ff[hof_pkg::CENTER_IDX][SW-1], window_ff[hof_pkg::CENTER_IDX]};
   assign center_diff = center_ext - chain_median;
   assign center_abs  = center_diff[DW-1] ? -center_diff : center_diff;

   // exact test: dev * 2^24 <= (thr * 1.4826) * MAD, full product never truncated
   assign bound  = hof_pkg::BOUND_W'(prod_lo_ff) +
                   (scale_ff[hof_pkg::PROD_W-1] ? (hof_pkg::BOUND_W'(mad_ff) << SW) : '0);
   assign lhs    = hof_pkg::BOUND_W'(dev_ff) << hof_pkg::FRAC_SHIFT;
   assign pass_s = (lhs <= bound);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      window_in     = window_ff;
      threshold_in  = threshold_ff;
      med_in        = med_ff;
      dev_in        = dev_ff;
      mad_in        = mad_ff;
      scale_in      = scale_ff;
      prod_lo_in    = prod_lo_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      sample_out_in = sample_out_ff;
      flag_in       = flag_ff;
      seen_in       = seen_ff;
      chain_clear   = 1'b0;
      out_load      = 1'b0;

      if (csr_valid && csr_ready) begin
         threshold_in = csr_wdata;
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               for (int i = 0; i < NW - 1; i++) begin
                  window_in[i] = window_ff[i+1];
               end
               window_in[NW-1] = req_tdata;
               cnt_in          = '0;
               chain_clear     = 1'b1;
               state_in        = ST_SORT_VAL;
            end
         end
         ST_SORT_VAL: begin
            cnt_in = cnt_ff + 1'b1;
            if (last_cnt) begin
               med_in      = chain_median;
               dev_in      = center_abs[SW-1:0];
               cnt_in      = '0;
               chain_clear = 1'b1;
               state_in    = ST_SORT_DEV;
            end
         end
         ST_SORT_DEV: begin
            cnt_in = cnt_ff + 1'b1;
            if (last_cnt) begin
               mad_in   = chain_median[SW-1:0];
               cnt_in   = '0;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            scale_in = hof_pkg::PROD_W'(threshold_ff) *
                       hof_pkg::PROD_W'(hof_pkg::SCALE_Q1_16);
            state_in = ST_PRODUCT;
         end
         ST_PRODUCT: begin
            prod_lo_in = hof_pkg::LOW_PROD_W'(scale_ff[SW-1:0]) *
                         hof_pkg::LOW_PROD_W'(mad_ff);
            state_in   = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (out_load) begin
         rsp_valid_in  = 1'b1;
         sample_out_in = pass_s ? window_ff[hof_pkg::CENTER_IDX] : med_ff[SW-1:0];
         flag_in       = !pass_s;
         count_in      = pass_s ? count_ff : count_ff + 1'b1;
         seen_in       = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         threshold_ff <= hof_pkg::THR_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NW; i++) begin
            window_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         threshold_ff <= threshold_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         window_ff    <= window_in;
      end
      med_ff        <= med_in;
      dev_ff        <= dev_in;
      mad_ff        <= mad_in;
      scale_ff      <= scale_in;
      prod_lo_ff    <= prod_lo_in;
      sample_out_ff <= sample_out_in;
      flag_ff       <= flag_in;
      seen_ff       <= seen_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {seen_ff, sample_out_ff};
   assign rsp_tuser  = flag_ff;

   // one item in flight: a transfer closes the input side
   `HOF_ASSERT(a_busy_blocks_req, (req_tvalid && req_tready) |=> !req_tready)
   // counter steps exactly on an outlier result
   `HOF_ASSERT(a_count_steps, (out_load && !pass_s) |=> (count_ff == $past(count_ff) + 32'd1))
   `HOF_ASSERT(a_count_holds, !(out_load && !pass_s) |=> (count_ff == $past(count_ff)))
   // results only come out of the decision step
   `HOF_ASSERT(a_result_from_decide, $rose(rsp_tvalid) |-> $past(state_ff == ST_DECIDE))

endmodule
